// ===== sv/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types and codes for the stream stall watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned LimitW = 32;
  localparam int unsigned ReopW  = 8;

  // Request codes carried by an input item.
  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_TRIP    = 2'd3
  } req_kind_t;

  // Verdict codes carried by a result item.
  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_REOPEN  = 2'd1,
    VERDICT_GIVE_UP = 2'd2
  } verdict_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_GRACE_LIMIT  = 2'd0,
    CFG_STALL_LIMIT  = 2'd1,
    CFG_REOPEN_LIMIT = 2'd2
  } cfg_idx_t;

  // One registered request.
  typedef struct packed {
    req_kind_t          kind;
    logic [TimeW-1:0]   now_ms;
    logic [CountW-1:0]  progress;
  } ssw_req_t;

  // Evaluation result handed back to the top level.
  typedef struct packed {
    logic              has_out;
    verdict_t          verdict;
    logic [ReopW-1:0]  reopens;
  } ssw_res_t;

  // Limits presented to the evaluation core.
  typedef struct packed {
    logic [LimitW-1:0] grace;
    logic [LimitW-1:0] stall;
    logic [ReopW-1:0]  reopen;
  } ssw_limits_t;

endpackage

`default_nettype wire

// ===== sv/ssw_core.sv =====
// ----------------------------------------------------------------------------
// ssw_core
// Watchdog state and the single-pass evaluation of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_core
  import ssw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire ssw_req_t    req,
  input  wire ssw_limits_t limits,
  output ssw_res_t         res
);

  logic [TimeW-1:0]  mark_time_r, mark_time_nxt;
  logic [CountW-1:0] last_prog_r, last_prog_nxt;
  logic              flowing_r, flowing_nxt;
  logic [ReopW-1:0]  reopen_cnt_r, reopen_cnt_nxt;

  logic              behind;
  logic [TimeW-1:0]  quiet;
  logic [LimitW-1:0] limit_sel;
  logic              under_limit;
  logic              trip;
  logic              give_up;

  // Quiet time since the mark, clamped to zero when time runs behind it.
  assign behind      = (req.now_ms <= mark_time_r);
  assign quiet       = req.now_ms - mark_time_r;
  assign limit_sel   = flowing_r ? limits.stall : limits.grace;
  assign under_limit = behind ? (limit_sel != '0)
                              : (quiet < {{(TimeW-LimitW){1'b0}}, limit_sel});
  assign give_up     = (reopen_cnt_r >= limits.reopen);

  // Next state and verdict for the request at hand.
  always_comb begin
    mark_time_nxt  = mark_time_r;
    last_prog_nxt  = last_prog_r;
    flowing_nxt    = flowing_r;
    reopen_cnt_nxt = reopen_cnt_r;
    trip           = 1'b0;
    res.has_out    = 1'b0;
    res.verdict    = VERDICT_OK;
    case (req.kind)
      REQ_START: begin
        reopen_cnt_nxt = '0;
        mark_time_nxt  = req.now_ms;
        last_prog_nxt  = req.progress;
        flowing_nxt    = 1'b0;
      end
      REQ_RESTART: begin
        mark_time_nxt = req.now_ms;
        last_prog_nxt = req.progress;
        flowing_nxt   = 1'b0;
      end
      REQ_CHECK: begin
        res.has_out = 1'b1;
        if (req.progress != last_prog_r) begin
          last_prog_nxt  = req.progress;
          mark_time_nxt  = req.now_ms;
          flowing_nxt    = 1'b1;
          reopen_cnt_nxt = '0;
        end else begin
          trip = !under_limit;
        end
      end
      REQ_TRIP: begin
        res.has_out = 1'b1;
        trip        = 1'b1;
      end
      default: begin
        res.has_out = 1'b0;
      end
    endcase

    // A trip either spends one more reopen or gives up.
    if (trip) begin
      if (give_up) begin
        res.verdict = VERDICT_GIVE_UP;
      end else begin
        res.verdict    = VERDICT_REOPEN;
        reopen_cnt_nxt = reopen_cnt_r + ReopW'(1);
      end
    end
    res.reopens = reopen_cnt_nxt;
  end

  // State registers advance when the request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_time_r  <= '0;
      last_prog_r  <= '0;
      flowing_r    <= 1'b0;
      reopen_cnt_r <= '0;
    end else if (fire) begin
      mark_time_r  <= mark_time_nxt;
      last_prog_r  <= last_prog_nxt;
      flowing_r    <= flowing_nxt;
      reopen_cnt_r <= reopen_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stream_stall_watchdog.sv =====
// ----------------------------------------------------------------------------
// stream_stall_watchdog
// Watches a sampled progress counter and judges stalls per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a request: start, restarted,
//   check or forced trip, with a 48-bit ms timestamp and a counter sample.
//   Output channel (out_valid / out_stall) carries one result item for each
//   check or forced trip: a verdict (ok, reopen, give up) and the reopen
//   count after the request. Start and restarted produce no result.
//   Configuration port (cfg_valid / cfg_ready) writes the grace limit, the
//   stall limit and the reopen limit; cfg_ready is always high. Write it
//   only while no request is in flight.
//   A request is accepted into the input register and evaluated out of it
//   into the result register; a stalled result there can hold it back.
//   Throughput: one request per cycle unless a stalled result holds it,
//   limited by the single evaluation pass (one 48-bit subtract and compare).
//   Reset clears the watchdog state, both pipeline registers and restores
//   the limits to 2000 ms, 500 ms and 3 reopens.
//   When the receiver stalls, the held result blocks only a request that
//   would produce a result; start and restarted still pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_stall_watchdog
  import ssw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [TimeW-1:0]  in_now_ms,
  input  wire logic [CountW-1:0] in_progress_count,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_verdict,
  output logic [ReopW-1:0]       out_reopens_used,
  // Configuration write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [LimitW-1:0] cfg_data
);

  logic              s1_valid_r;
  ssw_req_t          s1_req_r;
  logic              s1_adv;
  ssw_res_t          res;
  ssw_limits_t       limits_r;
  logic              out_valid_r;
  verdict_t          out_verdict_r;
  logic [ReopW-1:0]  out_reopens_r;

  // The input register drains unless its result would collide with a
  // stalled result in the output register.
  assign s1_adv   = s1_valid_r && (!res.has_out || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r.kind     <= req_kind_t'(in_req_type);
      s1_req_r.now_ms   <= in_now_ms;
      s1_req_r.progress <= in_progress_count;
    end
  end

  // Evaluation against the watchdog state.
  ssw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .req    (s1_req_r),
    .limits (limits_r),
    .res    (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.has_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.has_out) begin
      out_verdict_r <= res.verdict;
      out_reopens_r <= res.reopens;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_reopens_used = out_reopens_r;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.grace  <= LimitW'(2000);
      limits_r.stall  <= LimitW'(500);
      limits_r.reopen <= ReopW'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRACE_LIMIT:  limits_r.grace  <= cfg_data;
        CFG_STALL_LIMIT:  limits_r.stall  <= cfg_data;
        CFG_REOPEN_LIMIT: limits_r.reopen <= cfg_data[ReopW-1:0];
        default: begin
          limits_r <= limits_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssw_checker.sv =====
// ----------------------------------------------------------------------------
// ssw_checker
// Port-level checks for the stream stall watchdog, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_checker
  import ssw_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       out_verdict,
  input wire logic [ReopW-1:0] out_reopens_used
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only the three defined verdicts ever leave the block.
  a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_OK || out_verdict == VERDICT_REOPEN ||
                   out_verdict == VERDICT_GIVE_UP))
    else $error("undefined verdict code");

  // A reopen always spends one count, so the count reported is nonzero.
  a_reopen_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_REOPEN) |-> (out_reopens_used != '0))
    else $error("reopen reported with zero reopens used");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_verdict) && $stable(out_reopens_used)))
    else $error("stalled result changed");

endmodule

bind stream_stall_watchdog ssw_checker u_ssw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_verdict      (out_verdict),
  .out_reopens_used (out_reopens_used)
);

`default_nettype wire

// ===== verif/tb_stream_stall_watchdog.sv =====
// ----------------------------------------------------------------------------
// tb_stream_stall_watchdog
// Self-checking bench for the stream stall watchdog. A short table of probe
// requests covers the limit edges, clamped quiet time, restart and start,
// zero limits and the reopen ceiling. A burst of forced trips then walks the
// reopen count to its top, and three random phases run armed check
// sequences with noise under changing limits and handshake pressure. Every
// verdict is compared with a typed row's own expectation or with a behavioral prediction kept in this bench.
// ----------------------------------------------------------------------------
module tb_stream_stall_watchdog;
  import ssw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 480;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [LimitW-1:0] LimitMax = '1;
  // Index past the last register; a write there must change nothing.
  localparam logic [1:0] CfgIdxNone = 2'd3;

  // One expected result item.
  typedef struct {
    verdict_t          verdict;
    logic [ReopW-1:0]  reopens;
  } verdict_rec_t;

  // One row of the probe table; typed rows carry their own expectation.
  typedef struct {
    req_kind_t         kind;
    logic [TimeW-1:0]  now;
    logic [CountW-1:0] sample;
    bit                typed;
    verdict_t          verdict;
    logic [ReopW-1:0]  reopens;
  } probe_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = REQ_START;
  logic [TimeW-1:0]  in_now_ms = '0;
  logic [CountW-1:0] in_progress_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_verdict;
  logic [ReopW-1:0]  out_reopens_used;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_GRACE_LIMIT;
  logic [LimitW-1:0] cfg_data = '0;

  // Predicted watchdog state and limits.
  logic [TimeW-1:0]  mark_ms;
  logic [CountW-1:0] last_sample;
  logic              flowing;
  logic [ReopW-1:0]  reopens_now;
  logic [LimitW-1:0] grace_lim;
  logic [LimitW-1:0] stall_lim;
  logic [ReopW-1:0]  reopen_lim;

  verdict_rec_t pending_verdicts[$];
  probe_row_t   probe_rows[$];

  // Expectation override for typed probe rows, set with the item.
  bit               fixed_row = 1'b0;
  verdict_t         fixed_verdict = VERDICT_OK;
  logic [ReopW-1:0] fixed_reopens = '0;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 75;
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned limit_writes = 0;
  int unsigned cycle_cnt = 0;

  stream_stall_watchdog u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_now_ms         (in_now_ms),
    .in_progress_count (in_progress_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict),
    .out_reopens_used  (out_reopens_used),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A trip gives up once the reopen budget is spent, else uses one reopen.
  function automatic verdict_t trip_verdict();
    if (reopens_now >= reopen_lim) return VERDICT_GIVE_UP;
    reopens_now = reopens_now + 1'b1;
    return VERDICT_REOPEN;
  endfunction

  // Advances the predicted state by one request and queues its verdict.
  function automatic void judge_request(req_kind_t kind, logic [TimeW-1:0] now,
                                        logic [CountW-1:0] sample);
    logic [TimeW-1:0]  quiet;
    logic [LimitW-1:0] lim;
    verdict_rec_t      rec;
    bit                has_result;
    has_result = 1'b1;
    rec.verdict = VERDICT_OK;
    case (kind)
      REQ_START, REQ_RESTART: begin
        if (kind == REQ_START) reopens_now = '0;
        mark_ms = now;
        last_sample = sample;
        flowing = 1'b0;
        has_result = 1'b0;
      end
      REQ_CHECK: begin
        if (sample != last_sample) begin
          last_sample = sample;
          mark_ms = now;
          flowing = 1'b1;
          reopens_now = '0;
        end else begin
          // Quiet time clamps to zero when the clock reads behind the mark.
          quiet = (now > mark_ms) ? now - mark_ms : '0;
          lim = flowing ? stall_lim : grace_lim;
          if (quiet >= {{(TimeW-LimitW){1'b0}}, lim}) rec.verdict = trip_verdict();
        end
      end
      default: rec.verdict = trip_verdict();
    endcase
    rec.reopens = reopens_now;
    if (fixed_row) begin
      rec.verdict = fixed_verdict;
      rec.reopens = fixed_reopens;
    end
    if (has_result) pending_verdicts.push_back(rec);
  endfunction

  function automatic void apply_limit_write(logic [1:0] idx, logic [LimitW-1:0] data);
    case (idx)
      CFG_GRACE_LIMIT:  grace_lim = data;
      CFG_STALL_LIMIT:  stall_lim = data;
      CFG_REOPEN_LIMIT: reopen_lim = data[ReopW-1:0];
      default: ;
    endcase
  endfunction

  // Handshake monitor: checks results first, then predicts new requests.
  always @(posedge clk) begin
    verdict_rec_t want;
    if (!rst_n) begin
      mark_ms <= '0;
      last_sample <= '0;
      flowing <= 1'b0;
      reopens_now <= '0;
      grace_lim <= 32'd2000;
      stall_lim <= 32'd500;
      reopen_lim <= 8'd3;
    end else begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result item: verdict %0d reopens_used %0d",
                 out_verdict, out_reopens_used);
          fail_cnt++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, out_verdict);
            fail_cnt++;
          end
          if (out_reopens_used !== want.reopens) begin
            $error("reopens_used: expected %0d, actual %0d", want.reopens,
                   out_reopens_used);
            fail_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_limit_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) judge_request(req_kind_t'(in_req_type), in_now_ms,
                                               in_progress_count);
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Presents one request after a random gap and holds it until taken.
  task automatic send_req(req_kind_t kind, logic [TimeW-1:0] now,
                          logic [CountW-1:0] sample, bit typed, verdict_t verdict,
                          logic [ReopW-1:0] reopens);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    fixed_row = typed;
    fixed_verdict = verdict;
    fixed_reopens = reopens;
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_now_ms <= now;
    in_progress_count <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_limit(logic [1:0] idx, logic [LimitW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_writes++;
    @(negedge clk);
  endtask

  // Sender holds off until every verdict is in and the pipeline has emptied.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_probes(int first, int last);
    for (int i = first; i <= last; i++)
      send_req(probe_rows[i].kind, probe_rows[i].now, probe_rows[i].sample,
               probe_rows[i].typed, probe_rows[i].verdict, probe_rows[i].reopens);
  endtask

  // Mostly well-formed check sequences around the active limit, plus noise.
  task automatic send_random_req();
    int unsigned       pick;
    logic [LimitW-1:0] lim;
    logic [TimeW-1:0]  now;
    logic [CountW-1:0] sample;
    req_kind_t         kind;
    int unsigned       span;
    pick = $urandom_range(99);
    lim = flowing ? stall_lim : grace_lim;
    now = {16'($urandom), 32'($urandom)};
    sample = $urandom;
    if (pick < 5) begin
      kind = REQ_START;
      if (pick < 4) now = mark_ms + $urandom_range(0, 100);
    end else if (pick < 10) begin
      kind = REQ_RESTART;
      if (pick < 9) now = mark_ms + $urandom_range(0, 100);
      if (pick < 8) sample = last_sample;
    end else if (pick < 20) begin
      kind = REQ_TRIP;
    end else if (pick < 28) begin
      kind = REQ_CHECK;
      if (pick < 24) sample = last_sample;
    end else begin
      kind = REQ_CHECK;
      span = (lim > 32'd100000) ? 200000 : 2 * lim + 2;
      case ($urandom_range(4))
        0: now = mark_ms + {{(TimeW-LimitW){1'b0}}, lim} - $urandom_range(0, 1);
        1: now = mark_ms - $urandom_range(1, 100);
        default: now = mark_ms + $urandom_range(0, span);
      endcase
      sample = ($urandom_range(3) == 0) ? last_sample + $urandom_range(1, 3) : last_sample;
    end
    send_req(kind, now, sample, 1'b0, VERDICT_OK, '0);
  endtask

  // Watchdog on the run itself.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("stream_stall_watchdog: mismatch");
    $finish;
  end

  initial begin
    // Reset limits: grace 2000, stall 500, three reopens.
    probe_rows.push_back('{REQ_CHECK, 48'd0, 32'd0, 1, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, 48'd2000, 32'd0, 1, VERDICT_REOPEN, 8'd1});
    probe_rows.push_back('{REQ_CHECK, 48'd1999, 32'd0, 1, VERDICT_OK, 8'd1});
    probe_rows.push_back('{REQ_TRIP, TimeMax, CountMax, 1, VERDICT_REOPEN, 8'd2});
    probe_rows.push_back('{REQ_TRIP, 48'd0, 32'd0, 1, VERDICT_REOPEN, 8'd3});
    probe_rows.push_back('{REQ_TRIP, 48'd0, 32'd0, 1, VERDICT_GIVE_UP, 8'd3});
    probe_rows.push_back('{REQ_CHECK, 48'd5, CountMax, 1, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, 48'd504, CountMax, 1, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, 48'd505, CountMax, 1, VERDICT_REOPEN, 8'd1});
    probe_rows.push_back('{REQ_CHECK, 48'd0, CountMax, 0, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_RESTART, 48'd1000, 32'd7, 0, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, 48'd3000, 32'd7, 1, VERDICT_REOPEN, 8'd2});
    probe_rows.push_back('{REQ_START, TimeMax, 32'd0, 0, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, TimeMax, 32'd0, 1, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, 48'd0, 32'd0, 0, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_CHECK, TimeMax, 32'd1, 1, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_TRIP, 48'd0, 32'd0, 1, VERDICT_REOPEN, 8'd1});
    // All limits zero: every quiet check trips and every trip gives up.
    probe_rows.push_back('{REQ_CHECK, TimeMax, 32'd1, 1, VERDICT_GIVE_UP, 8'd1});
    probe_rows.push_back('{REQ_START, 48'd0, 32'd0, 0, VERDICT_OK, 8'd0});
    probe_rows.push_back('{REQ_TRIP, 48'd0, 32'd0, 1, VERDICT_GIVE_UP, 8'd0});
    probe_rows.push_back('{REQ_CHECK, 48'd0, 32'd0, 1, VERDICT_GIVE_UP, 8'd0});
    // All limits at their maximum.
    probe_rows.push_back('{REQ_CHECK, TimeMax, 32'd0, 1, VERDICT_REOPEN, 8'd1});
    probe_rows.push_back('{REQ_CHECK, 48'd1, 32'd0, 1, VERDICT_OK, 8'd1});
    probe_rows.push_back('{REQ_CHECK, 48'd3, 32'd5, 1, VERDICT_OK, 8'd0});

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Probe table at the reset limits.
    run_probes(0, 16);
    wait_idle();
    write_limit(CFG_GRACE_LIMIT, '0);
    write_limit(CFG_STALL_LIMIT, '0);
    write_limit(CFG_REOPEN_LIMIT, {24'($urandom), 8'd0});
    cfg_valid <= 1'b0;
    @(negedge clk);
    run_probes(17, 20);
    wait_idle();
    write_limit(CFG_GRACE_LIMIT, LimitMax);
    write_limit(CFG_STALL_LIMIT, LimitMax);
    write_limit(CFG_REOPEN_LIMIT, {24'($urandom), 8'hFF});
    write_limit(CfgIdxNone, '0);
    cfg_valid <= 1'b0;
    @(negedge clk);
    run_probes(21, 23);

    // Forced trips walk the reopen count to 255, then give up.
    repeat (256)
      send_req(REQ_TRIP, {16'($urandom), 32'($urandom)}, $urandom, 1'b0, VERDICT_OK, '0);

    // Random phases under shifting back-pressure and limits.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 38; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wait_idle();
      write_limit(CFG_GRACE_LIMIT, $urandom_range(0, 3000));
      write_limit(CFG_STALL_LIMIT, $urandom_range(0, 800));
      write_limit(CFG_REOPEN_LIMIT, {24'($urandom), 8'($urandom_range(0, 6))});
      cfg_valid <= 1'b0;
      @(negedge clk);
      for (int n = 0; n < PhaseItems; n++) begin
        // Halfway through, drain fully and retune the stall limit.
        if (n == PhaseItems / 2) begin
          wait_idle();
          write_limit(CFG_STALL_LIMIT, $urandom_range(1, 1500));
          cfg_valid <= 1'b0;
          @(negedge clk);
        end
        send_random_req();
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected verdicts never arrived", pending_verdicts.size());
      fail_cnt++;
    end
    $display("Sent %0d requests, checked %0d verdicts, made %0d limit writes.",
             items_sent, verdicts_seen, limit_writes);
    $display("Covered limit edges, clamped quiet time, zero limits and the reopen ceiling.");
    if (fail_cnt == 0) begin
      $display("stream_stall_watchdog: match");
    end else begin
      $display("stream_stall_watchdog: mismatch");
    end
    $finish;
  end

endmodule
